### rtl/vlsag_pkg.sv
// ----------------------------------------------------------------------------
// Vector load/store address generator package
// Shared word types, operation codes and limits of the address generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vlsag_pkg;

  // Default limit on the element count of one operation.
  localparam int unsigned MAX_ELEMS_DEF = 4096;

  // Lane width limits and reset value of the lane width register.
  localparam logic [6:0] LANE_MIN   = 7'd1;
  localparam logic [6:0] LANE_MAX   = 7'd64;
  localparam logic [6:0] LANE_RESET = 7'd8;

  // Word modes.
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Access kinds.
  localparam logic [1:0] KIND_UNIT    = 2'd0;
  localparam logic [1:0] KIND_STRIDED = 2'd1;
  localparam logic [1:0] KIND_INDEXED = 2'd2;
  localparam logic [1:0] KIND_RSVD    = 2'd3;

  typedef struct packed {
    logic               mode;
    logic        [63:0] base_addr;
    logic        [12:0] elem_count;
    logic        [1:0]  elem_size_log2;
    logic        [1:0]  access_kind;
    logic signed [63:0] stride;
    logic               store_op;
    logic        [63:0] index_offset;
  } in_word_t;

  typedef struct packed {
    logic [63:0] req_addr;
    logic [6:0]  req_size;
    logic        req_write;
    logic [14:0] data_offset;
    logic        last;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/vector_load_store_address_generator_top.sv
// ----------------------------------------------------------------------------
// Vector load/store address generator
// Turns vector memory operations into a sequence of memory requests.
//
// The input channel (in_valid, in_stall, in_word) carries two kinds of words.
// A start word loads a new operation: base address, element count, element
// size, access kind, stride and direction; it replaces any operation still
// pending and never produces a request. An advance word issues the next
// request of the pending operation on the output channel (out_valid,
// out_stall, out_word); with nothing pending it produces nothing.
// The configuration port (cfg_we, cfg_wdata) sets the largest unit-stride
// burst in bytes and should be written only while the block is idle.
// An accepted word sits in the input register, is worked on there and its
// request is registered in the output register. One word is accepted every
// cycle while no request is stalled; the rate is set by the single 64-bit
// address adder and the state update. When the receiver stalls, the request
// waits in the output register and the input channel stalls as soon as a
// word is waiting behind it. Synchronous reset clears the pending operation,
// both pipeline registers and sets the lane width back to eight bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vector_load_store_address_generator_top #(
  parameter int unsigned MAX_ELEMS = vlsag_pkg::MAX_ELEMS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  vlsag_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  wire                   out_stall,
  output vlsag_pkg::out_word_t  out_word,
  input  wire                   cfg_we,
  input  wire [6:0]             cfg_wdata
);

  import vlsag_pkg::*;

  // Remaining bytes must hold MAX_ELEMS elements of eight bytes.
  localparam int REM_W = $clog2(MAX_ELEMS * 8 + 1);
  localparam int CMP_W = (REM_W > 7) ? REM_W : 7;

  // Configuration.
  logic [6:0]       lane_r;

  // Input register.
  logic             v1_r;
  in_word_t         in_r;

  // Operation state.
  logic [REM_W-1:0] rem_r,    rem_nxt;
  logic [63:0]      addr_r,   addr_nxt;
  logic [14:0]      off_r,    off_nxt;
  logic [63:0]      stride_r, stride_nxt;
  logic [1:0]       esz_r,    esz_nxt;
  logic [1:0]       kind_r,   kind_nxt;
  logic             wr_r,     wr_nxt;

  // Output register.
  logic             out_valid_r;
  out_word_t        out_r, out_nxt;

  // Datapath.
  logic             out_free;
  logic             proc;
  logic             produce;
  logic [6:0]       lane_eff;
  logic [6:0]       cap;
  logic [CMP_W-1:0] rem_ext;
  logic [CMP_W-1:0] cap_ext;
  logic [6:0]       size;
  logic [63:0]      addend;
  logic [63:0]      sum;
  logic [REM_W-1:0] rem_after;
  logic [31:0]      cnt_ext;
  logic [31:0]      cnt_sat;

  // The output register can take a new request when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign proc     = v1_r && out_free;
  assign in_stall = v1_r && !out_free;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  always_comb begin
    // Lane width clamped to its legal range.
    if (lane_r == 7'd0) begin
      lane_eff = LANE_MIN;
    end else if (lane_r > LANE_MAX) begin
      lane_eff = LANE_MAX;
    end else begin
      lane_eff = lane_r;
    end

    // Unit-stride moves up to one lane, other kinds one element.
    cap     = (kind_r == KIND_UNIT) ? lane_eff : (7'd1 << esz_r);
    rem_ext = CMP_W'(rem_r);
    cap_ext = CMP_W'(cap);
    size    = (rem_ext < cap_ext) ? 7'(rem_ext) : cap;

    // One adder serves all three kinds.
    case (kind_r)
      KIND_STRIDED: addend = stride_r;
      KIND_INDEXED: addend = in_r.index_offset;
      default:      addend = 64'(size);
    endcase
    sum       = addr_r + addend;
    rem_after = rem_r - REM_W'(size);

    produce = (in_r.mode == MODE_ADVANCE) && (rem_r != '0);

    // Element count saturated at the configured maximum.
    cnt_ext = 32'(in_r.elem_count);
    cnt_sat = (cnt_ext > MAX_ELEMS) ? MAX_ELEMS : cnt_ext;

    rem_nxt    = rem_r;
    addr_nxt   = addr_r;
    off_nxt    = off_r;
    stride_nxt = stride_r;
    esz_nxt    = esz_r;
    kind_nxt   = kind_r;
    wr_nxt     = wr_r;

    out_nxt.req_addr    = (kind_r == KIND_INDEXED) ? sum : addr_r;
    out_nxt.req_size    = size;
    out_nxt.req_write   = wr_r;
    out_nxt.data_offset = off_r;
    out_nxt.last        = (rem_after == '0);

    if (proc) begin
      if (in_r.mode == MODE_START) begin
        rem_nxt    = REM_W'(cnt_sat << in_r.elem_size_log2);
        addr_nxt   = in_r.base_addr;
        off_nxt    = '0;
        stride_nxt = in_r.stride;
        esz_nxt    = in_r.elem_size_log2;
        kind_nxt   = (in_r.access_kind == KIND_RSVD) ? KIND_UNIT : in_r.access_kind;
        wr_nxt     = in_r.store_op;
      end else if (produce) begin
        rem_nxt  = rem_after;
        addr_nxt = (kind_r == KIND_INDEXED) ? addr_r : sum;
        off_nxt  = off_r + 15'(size);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r      <= LANE_RESET;
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      addr_r      <= '0;
      off_r       <= '0;
      stride_r    <= '0;
      esz_r       <= '0;
      kind_r      <= KIND_UNIT;
      wr_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        lane_r <= cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        v1_r <= 1'b1;
      end else if (proc) begin
        v1_r <= 1'b0;
      end
      if (proc && produce) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      rem_r    <= rem_nxt;
      addr_r   <= addr_nxt;
      off_r    <= off_nxt;
      stride_r <= stride_nxt;
      esz_r    <= esz_nxt;
      kind_r   <= kind_nxt;
      wr_r     <= wr_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_word;
    end
    if (proc && produce) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/vlsag_checker.sv
// ----------------------------------------------------------------------------
// Vector load/store address generator checker
// Port-level assertions on the address generator, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vlsag_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_stall,
  input vlsag_pkg::in_word_t   in_word,
  input wire                   out_valid,
  input wire                   out_stall,
  input vlsag_pkg::out_word_t  out_word
);

  import vlsag_pkg::*;

  // A stalled request stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled request changed or vanished");

  // The input side stalls only while the receiver holds back a request.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked request");

  // An accepted start word never brings up a request.
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.mode == MODE_START) |=> ##1 !$rose(out_valid))
    else $error("start word produced a request");

  // Reset leaves no request valid and the input side unstalled.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind vector_load_store_address_generator_top vlsag_checker u_vlsag_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
